// ===== design/ssg_pkg.sv =====
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared widths, constants, stage payload types and helper functions for the
// stereo gain pipeline.
// ----------------------------------------------------------------------------
package ssg_pkg;

    localparam int D2_W   = 36;   // squared distance, 2^-16 units
    localparam int NUM_W  = 36;   // dot-product numerators
    localparam int LEN_W  = 26;   // distance, 2^-16 units
    localparam int RAD_W  = 2 * LEN_W;
    localparam int SREM_W = LEN_W + 2;
    localparam int Q_W    = 18;   // quotient bits per division lane
    localparam int REM_W  = D2_W + 1;
    localparam int G_W    = 16;   // Q1.15 gains

    localparam logic [G_W-1:0]  UNITY      = 16'd32768;
    localparam logic [G_W-1:0]  REAR_SPAN  = 16'd8192;
    localparam logic [D2_W-1:0] NEAR_LIMIT = 36'd983040;  // 15 * 2^16
    localparam logic [REM_W-1:0] VOL_REM0  = 37'd122880;  // (15 * 2^31) >> Q_W

    localparam int FRONT_LAT = 3;
    localparam int BACK_LAT  = 3;

    typedef struct packed {
        logic                    spatial;
        logic [D2_W-1:0]         d2;
        logic signed [NUM_W-1:0] num_r;
        logic signed [NUM_W-1:0] num_f;
    } geo_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   low;   // dividend bits out, quotient bits in
    } lane_t;

    typedef struct packed {
        logic            spatial;
        logic [D2_W-1:0] d2;
        logic            neg_r;
        logic            neg_f;
        logic [Q_W-1:0]  q_r;
        logic [Q_W-1:0]  q_f;
        logic [Q_W-1:0]  q_vol;
    } quo_t;

    // one restoring-division step
    function automatic lane_t div_step(input lane_t l, input logic [D2_W-1:0] dv);
        logic [REM_W:0] t;
        lane_t          o;
        t = {l.rem, l.low[Q_W-1]};
        if (t >= {2'b00, dv}) begin
            t     = t - {2'b00, dv};
            o.low = {l.low[Q_W-2:0], 1'b1};
        end else begin
            o.low = {l.low[Q_W-2:0], 1'b0};
        end
        o.rem = t[REM_W-1:0];
        return o;
    endfunction

    function automatic logic [NUM_W-1:0] abs_num(input logic signed [NUM_W-1:0] v);
        return v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
    endfunction

endpackage

// ===== design/ssg_front.sv =====
// ----------------------------------------------------------------------------
// ssg_front
// Offsets from the eye, squares and dot-product terms, then their sums.
// ----------------------------------------------------------------------------
module ssg_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [175:0]          in_data,
    input  logic                  in_spatial,
    output logic                  out_valid,
    output ssg_pkg::geo_t         out_geo
);
    import ssg_pkg::*;

    logic [2:0] valid_reg;

    logic signed [17:0] dx_reg, dy_reg, dz_reg;
    logic signed [17:0] rx_reg, ry_reg, rz_reg, fx_reg, fy_reg, fz_reg;
    logic               sp1_reg, sp2_reg;
    logic signed [35:0] sqx_reg, sqy_reg, sqz_reg;
    logic signed [35:0] prx_reg, pry_reg, prz_reg, pfx_reg, pfy_reg, pfz_reg;
    geo_t               geo_reg;

    logic signed [17:0] px, py, ex, ey, ez;
    logic signed [17:0] dx_next, dy_next, dz_next;

    function automatic logic signed [17:0] ext(input logic [15:0] v);
        return $signed({{2{v[15]}}, v});
    endfunction

    always_comb begin
        px      = ext(in_data[15:0]);
        py      = ext(in_data[31:16]);
        ex      = ext(in_data[47:32]);
        ey      = ext(in_data[63:48]);
        ez      = ext(in_data[79:64]);
        dx_next = px - ex;
        dy_next = 18'sd16384 - py - ey;   // y flip
        dz_next = 18'sd128 - ez;          // source height 0.5
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            dz_reg  <= dz_next;
            rx_reg  <= ext(in_data[95:80]);
            ry_reg  <= ext(in_data[111:96]);
            rz_reg  <= ext(in_data[127:112]);
            fx_reg  <= ext(in_data[143:128]);
            fy_reg  <= ext(in_data[159:144]);
            fz_reg  <= ext(in_data[175:160]);
            sp1_reg <= in_spatial;

            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
            sqz_reg <= dz_reg * dz_reg;
            prx_reg <= dx_reg * rx_reg;
            pry_reg <= dy_reg * ry_reg;
            prz_reg <= dz_reg * rz_reg;
            pfx_reg <= dx_reg * fx_reg;
            pfy_reg <= dy_reg * fy_reg;
            pfz_reg <= dz_reg * fz_reg;
            sp2_reg <= sp1_reg;

            geo_reg.spatial <= sp2_reg;
            geo_reg.d2      <= D2_W'(sqx_reg) + D2_W'(sqy_reg) + D2_W'(sqz_reg);
            geo_reg.num_r   <= prx_reg + pry_reg + prz_reg;
            geo_reg.num_f   <= pfx_reg + pfy_reg + pfz_reg;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_geo   = geo_reg;

endmodule

// ===== design/ssg_sqrt.sv =====
// ----------------------------------------------------------------------------
// ssg_sqrt
// Pipelined restoring square root of d2 * 2^16, one result bit per stage.
// ----------------------------------------------------------------------------
module ssg_sqrt (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  ssg_pkg::geo_t         in_geo,
    output logic                  out_valid,
    output ssg_pkg::geo_t         out_geo,
    output logic [ssg_pkg::LEN_W-1:0] out_len
);
    import ssg_pkg::*;

    logic [LEN_W-1:0]  valid_reg;
    geo_t              geo_reg  [LEN_W];
    logic [RAD_W-1:0]  rad_reg  [LEN_W];
    logic [SREM_W-1:0] rem_reg  [LEN_W];
    logic [LEN_W-1:0]  root_reg [LEN_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LEN_W-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < LEN_W; k++) begin : g_stage
        logic [RAD_W-1:0]  rad_in;
        logic [SREM_W-1:0] rem_in;
        logic [LEN_W-1:0]  root_in;
        geo_t              geo_in;
        logic [SREM_W+1:0] t;
        logic [SREM_W+1:0] trial;

        if (k == 0) begin : g_first
            assign rad_in  = {in_geo.d2, 16'd0};
            assign rem_in  = '0;
            assign root_in = '0;
            assign geo_in  = in_geo;
        end else begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign geo_in  = geo_reg[k-1];
        end

        assign t     = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial = (SREM_W + 2)'({root_in, 2'b01});

        always_ff @(posedge aclk) begin
            if (en) begin
                geo_reg[k] <= geo_in;
                rad_reg[k] <= {rad_in[RAD_W-3:0], 2'b00};
                if (t >= trial) begin
                    rem_reg[k]  <= SREM_W'(t - trial);
                    root_reg[k] <= {root_in[LEN_W-2:0], 1'b1};
                end else begin
                    rem_reg[k]  <= SREM_W'(t);
                    root_reg[k] <= {root_in[LEN_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[LEN_W-1];
    assign out_geo   = geo_reg[LEN_W-1];
    assign out_len   = root_reg[LEN_W-1];

endmodule

// ===== design/ssg_div.sv =====
// ----------------------------------------------------------------------------
// ssg_div
// Three pipelined restoring dividers side by side: right and front
// projections over the distance, and the 15 / d^2 attenuation.
// ----------------------------------------------------------------------------
module ssg_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  ssg_pkg::geo_t             in_geo,
    input  logic [ssg_pkg::LEN_W-1:0] in_len,
    output logic                      out_valid,
    output ssg_pkg::quo_t             out_quo
);
    import ssg_pkg::*;

    logic [Q_W-1:0]  valid_reg;
    lane_t           lr_reg [Q_W];
    lane_t           lf_reg [Q_W];
    lane_t           lv_reg [Q_W];
    logic [D2_W-1:0] len_reg [Q_W];
    logic [D2_W-1:0] d2_reg  [Q_W];
    logic [Q_W-1:0]  sp_reg, nr_reg, nf_reg;

    logic [NUM_W-1:0] mag_r, mag_f;
    lane_t            lr0, lf0, lv0;

    always_comb begin
        mag_r     = abs_num(in_geo.num_r);
        mag_f     = abs_num(in_geo.num_f);
        // dividend is mag * 2^9; its top part seeds the remainder
        lr0.rem   = REM_W'(mag_r[NUM_W-1:9]);
        lr0.low   = {mag_r[8:0], 9'd0};
        lf0.rem   = REM_W'(mag_f[NUM_W-1:9]);
        lf0.low   = {mag_f[8:0], 9'd0};
        lv0.rem   = VOL_REM0;
        lv0.low   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[Q_W-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        lane_t           lr_in, lf_in, lv_in;
        logic [D2_W-1:0] len_in, d2_in;
        logic            sp_in, nr_in, nf_in;

        if (k == 0) begin : g_first
            assign lr_in  = lr0;
            assign lf_in  = lf0;
            assign lv_in  = lv0;
            assign len_in = D2_W'(in_len);
            assign d2_in  = in_geo.d2;
            assign sp_in  = in_geo.spatial;
            assign nr_in  = in_geo.num_r[NUM_W-1];
            assign nf_in  = in_geo.num_f[NUM_W-1];
        end else begin : g_next
            assign lr_in  = lr_reg[k-1];
            assign lf_in  = lf_reg[k-1];
            assign lv_in  = lv_reg[k-1];
            assign len_in = len_reg[k-1];
            assign d2_in  = d2_reg[k-1];
            assign sp_in  = sp_reg[k-1];
            assign nr_in  = nr_reg[k-1];
            assign nf_in  = nf_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                lr_reg[k]  <= div_step(lr_in, len_in);
                lf_reg[k]  <= div_step(lf_in, len_in);
                lv_reg[k]  <= div_step(lv_in, d2_in);
                len_reg[k] <= len_in;
                d2_reg[k]  <= d2_in;
                sp_reg[k]  <= sp_in;
                nr_reg[k]  <= nr_in;
                nf_reg[k]  <= nf_in;
            end
        end
    end

    always_comb begin
        out_quo.spatial = sp_reg[Q_W-1];
        out_quo.d2      = d2_reg[Q_W-1];
        out_quo.neg_r   = nr_reg[Q_W-1];
        out_quo.neg_f   = nf_reg[Q_W-1];
        out_quo.q_r     = lr_reg[Q_W-1].low;
        out_quo.q_f     = lf_reg[Q_W-1].low;
        out_quo.q_vol   = lv_reg[Q_W-1].low;
    end

    assign out_valid = valid_reg[Q_W-1];

endmodule

// ===== design/ssg_back.sv =====
// ----------------------------------------------------------------------------
// ssg_back
// Clamps, pan and rear factors, the volume-rear base product, then the two
// gain products. The last stage is the output register.
// ----------------------------------------------------------------------------
module ssg_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  ssg_pkg::quo_t       in_quo,
    output logic                out_valid,
    output logic [31:0]         out_data
);
    import ssg_pkg::*;

    logic [2:0]     valid_reg;
    logic [G_W-1:0] vol_reg, rear_reg, panl1_reg, panr1_reg;
    logic [G_W-1:0] base_reg, panl2_reg, panr2_reg;
    logic           sp1_reg, sp2_reg;
    logic [G_W-1:0] gl_reg, gr_reg;

    logic           zero, near;
    logic [G_W-1:0] mr, mf;
    logic [G_W-1:0] vol_next, rear_next, panl_next, panr_next;
    logic [31:0]    base_full, gl_full, gr_full;

    always_comb begin
        zero = (in_quo.d2 == '0);   // direction counts as zero
        near = (in_quo.d2 <= NEAR_LIMIT);
        mr   = (zero) ? '0 :
               (in_quo.q_r > Q_W'(UNITY)) ? UNITY : in_quo.q_r[G_W-1:0];
        mf   = (zero) ? '0 :
               (in_quo.q_f > Q_W'(REAR_SPAN)) ? REAR_SPAN : in_quo.q_f[G_W-1:0];
        vol_next  = near ? UNITY : in_quo.q_vol[G_W-1:0];
        panl_next = in_quo.neg_r ? UNITY : UNITY - mr;
        panr_next = in_quo.neg_r ? UNITY - mr : UNITY;
        rear_next = in_quo.neg_f ? UNITY - mf : UNITY;
        base_full = vol_reg * rear_reg;
        gl_full   = base_reg * panl2_reg;
        gr_full   = base_reg * panr2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vol_reg   <= vol_next;
            rear_reg  <= rear_next;
            panl1_reg <= panl_next;
            panr1_reg <= panr_next;
            sp1_reg   <= in_quo.spatial;

            base_reg  <= base_full[30:15];
            panl2_reg <= panl1_reg;
            panr2_reg <= panr1_reg;
            sp2_reg   <= sp1_reg;

            gl_reg    <= sp2_reg ? gl_full[30:15] : UNITY;
            gr_reg    <= sp2_reg ? gr_full[30:15] : UNITY;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = {gr_reg, gl_reg};

endmodule

// ===== design/spatial_stereo_gain_unit.sv =====
// ----------------------------------------------------------------------------
// spatial_stereo_gain_unit
// Left/right gain pair for one positional sound source.
// ----------------------------------------------------------------------------
// Usage:
//   Present one source plus listener pose per beat on the s_ channel
//   (s_tuser = spatial flag). Each accepted beat yields one m_ beat with the
//   Q1.15 left and right gains, in order.
//   The path runs through offsets and products, the bit-per-stage square
//   root, the bit-per-stage dividers, then clamping and the gain products.
//   One beat is accepted every cycle while the output is not stalled.
//   The whole pipeline advances together; when m_tvalid is high and
//   m_tready low it holds, and s_tready drops in the same cycle, so nothing
//   is lost or repeated. Bubbles travel as invalid stages.
//   Synchronous active-low reset clears every valid bit; the block accepts
//   beats as soon as reset is released.
// ----------------------------------------------------------------------------
module spatial_stereo_gain_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, eye_x, eye_y, eye_z, right_x/y/z, front_x/y/z (16b each)
    input  logic [175:0] s_tdata,
    // spatial
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // gain_left [15:0], gain_right [31:16]
    output logic [31:0]  m_tdata
);
    import ssg_pkg::*;

    logic              en;
    logic              f_valid, s_valid, d_valid;
    geo_t              f_geo, s_geo;
    logic [LEN_W-1:0]  s_len;
    quo_t              d_quo;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    ssg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .in_spatial(s_tuser),
        .out_valid (f_valid),
        .out_geo   (f_geo)
    );

    ssg_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (f_valid),
        .in_geo   (f_geo),
        .out_valid(s_valid),
        .out_geo  (s_geo),
        .out_len  (s_len)
    );

    ssg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_geo   (s_geo),
        .in_len   (s_len),
        .out_valid(d_valid),
        .out_quo  (d_quo)
    );

    ssg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (d_valid),
        .in_quo   (d_quo),
        .out_valid(m_tvalid),
        .out_data (m_tdata)
    );

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] <= UNITY) && (m_tdata[31:16] <= UNITY))
        else $error("gain above unity");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline stalled");

    a_stall_holds_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(d_quo))
        else $error("pipeline moved during stall");

endmodule
